// ===== sv/phns_pkg.sv =====
// ----------------------------------------------------------------------------
// phns_pkg: shared types and constants for the particle heading/noise step
// Field widths, fixed-point formats, CORDIC angle table and register codes.
// ----------------------------------------------------------------------------
package phns_pkg;

    // field widths
    localparam int POS_W      = 28;   // Q12.16 unsigned x, Q11.16 signed y positions
    localparam int VEL_W      = 18;   // Q1.16 velocities / headings
    localparam int NOISE_W    = 19;   // Q2.16 radians
    localparam int BOX_W      = 12;
    localparam int SPEED_W    = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // fixed point
    localparam int FRAC_BITS        = 16;
    localparam int Q30_SHIFT        = 30 - FRAC_BITS;
    localparam int CORDIC_STEPS_DEF = 16;

    // internal widths
    localparam int ANG_W   = 36;                  // Q30 angles and CORDIC vectors
    localparam int PROD_W  = 36;                  // speed * heading
    localparam int DELTA_W = PROD_W - FRAC_BITS;  // rounded step
    localparam int SUM_W   = 31;                  // x + step + 4 * box, never negative
    localparam int QUO_W   = SUM_W - FRAC_BITS;   // whole-unit part of that sum
    localparam int REM_STEPS = QUO_W;             // one restoring step per bit
    localparam int BLEN_W  = BOX_W + 1;           // box length, 0 read as 4096

    typedef logic        [POS_W-1:0]      pos_u_t;
    typedef logic signed [POS_W-1:0]      pos_s_t;
    typedef logic signed [VEL_W-1:0]      vel_t;
    typedef logic signed [NOISE_W-1:0]    noise_t;
    typedef logic        [BOX_W-1:0]      box_t;
    typedef logic        [SPEED_W-1:0]    speed_t;
    typedef logic        [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic        [CFG_DATA_W-1:0] cfg_data_t;
    typedef logic signed [ANG_W-1:0]      ang_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [DELTA_W-1:0]    delta_t;
    typedef logic        [QUO_W-1:0]      quo_t;
    typedef logic        [FRAC_BITS-1:0]  frac_t;
    typedef logic        [BLEN_W-1:0]     blen_t;

    // register codes
    localparam cfg_idx_t REG_BOX_LENGTH = CFG_IDX_W'(0);
    localparam cfg_idx_t REG_SPEED      = CFG_IDX_W'(1);

    localparam box_t   BOX_LENGTH_RST = BOX_W'(256);
    localparam speed_t SPEED_RST      = SPEED_W'(32768);

    // Q30 angle constants (truncated)
    localparam ang_t ANG_PI        = 36'sd3373259426;
    localparam ang_t ANG_TWO_PI    = 36'sd6746518852;
    localparam ang_t ANG_THREE_PI  = 36'sd10119778278;
    localparam ang_t ANG_HALF_PI   = 36'sd1686629713;
    localparam ang_t INV_GAIN      = 36'sd652032874;

    localparam ang_t  HEAD_ROUND = ANG_W'(64'd1 << (Q30_SHIFT - 1));
    localparam vel_t  HEAD_LIM   = VEL_W'(64'd1 << FRAC_BITS);
    localparam prod_t PROD_ROUND = PROD_W'(64'd1 << (FRAC_BITS - 1));

    localparam pos_s_t POS_MAX = {1'b0, {(POS_W - 1){1'b1}}};
    localparam pos_s_t POS_MIN = {1'b1, {(POS_W - 1){1'b0}}};

    // atan(2^-i) in Q30
    function automatic ang_t atan_q30(input logic [4:0] i);
        case (i)
            5'd0:    return 36'sd843314856;
            5'd1:    return 36'sd497837829;
            5'd2:    return 36'sd263043836;
            5'd3:    return 36'sd133525158;
            5'd4:    return 36'sd67021686;
            5'd5:    return 36'sd33543515;
            5'd6:    return 36'sd16775850;
            5'd7:    return 36'sd8388437;
            5'd8:    return 36'sd4194282;
            5'd9:    return 36'sd2097149;
            5'd10:   return 36'sd1048575;
            5'd11:   return 36'sd524287;
            5'd12:   return 36'sd262143;
            5'd13:   return 36'sd131071;
            5'd14:   return 36'sd65535;
            5'd15:   return 36'sd32767;
            5'd16:   return 36'sd16383;
            5'd17:   return 36'sd8191;
            5'd18:   return 36'sd4095;
            5'd19:   return 36'sd2047;
            5'd20:   return 36'sd1023;
            5'd21:   return 36'sd511;
            5'd22:   return 36'sd255;
            5'd23:   return 36'sd127;
            default: return '0;
        endcase
    endfunction

endpackage

// ===== sv/phns_if.sv =====
// ----------------------------------------------------------------------------
// phns_if: valid/ready channels of the particle heading/noise step unit
// One interface per direction; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface phns_particle_if import phns_pkg::*; ();
    logic   valid;
    logic   ready;
    pos_u_t pos_x;
    pos_s_t pos_y;
    vel_t   vel_x;
    vel_t   vel_y;
    noise_t noise_angle;

    modport source (
        output valid, output pos_x, output pos_y, output vel_x, output vel_y,
        output noise_angle, input ready
    );
    modport sink (
        input valid, input pos_x, input pos_y, input vel_x, input vel_y,
        input noise_angle, output ready
    );
endinterface

interface phns_result_if import phns_pkg::*; ();
    logic   valid;
    logic   ready;
    pos_u_t new_x;
    pos_s_t new_y;
    vel_t   new_vx;
    vel_t   new_vy;
    logic   y_saturated;
    logic   zero_velocity;

    modport source (
        output valid, output new_x, output new_y, output new_vx, output new_vy,
        output y_saturated, output zero_velocity, input ready
    );
    modport sink (
        input valid, input new_x, input new_y, input new_vx, input new_vy,
        input y_saturated, input zero_velocity, output ready
    );
endinterface

// ===== sv/particle_heading_noise_step_unit.sv =====
// ----------------------------------------------------------------------------
// particle_heading_noise_step_unit: one move of a self-propelled particle
// CORDIC heading extraction, noise rotation, step and periodic x wrap.
// ----------------------------------------------------------------------------
// Fully pipelined: one particle transfer per clock, sustained while the result
// channel is ready. Most of the depth lies in the two unrolled CORDIC passes
// (one stage per micro-rotation) and the 15-stage restoring remainder that
// folds x into the box. Every stage carries its own valid bit; a stage takes
// new data when it is empty or the stage after it moves, so bubbles collapse
// and input transfers keep being taken while a result waits at the output
// register, until every stage is full. ready on the particle channel is a
// combinational function of downstream ready and the stage valid bits.
// box_length and speed are sampled mid-pipe; write them only with the pipe
// drained. box_length 0 is taken as 4096.
// Reset clears the valid bits and loads the register defaults (256, 0.5).
// ----------------------------------------------------------------------------
module particle_heading_noise_step_unit
    import phns_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  cfg_idx_t       cfg_index,
    input  cfg_data_t      cfg_data,
    phns_particle_if.sink  particle,
    phns_result_if.source  result
);

    // stage map
    localparam int N        = CORDIC_STEPS;
    localparam int ST_SUM   = N + 1;          // heading + noise + pi
    localparam int ST_WRAP  = N + 2;          // into [-pi, pi)
    localparam int ST_FOLD  = N + 3;          // into [-pi/2, pi/2], rotation start
    localparam int ST_RND   = ST_FOLD + N + 1; // round and clamp heading
    localparam int ST_MUL   = ST_RND + 1;     // speed * heading
    localparam int ST_DLT   = ST_MUL + 1;     // rounded step
    localparam int ST_POS   = ST_DLT + 1;     // y saturate, x offset into positive range
    localparam int LAST     = ST_POS + REM_STEPS;

    // ------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------
    logic [LAST:0] v_reg;
    logic [LAST:0] en;

    box_t   box_length_reg;
    speed_t speed_reg;
    blen_t  blen;

    // ------------------------------------------------------------------
    // payload, indexed by stage number
    // ------------------------------------------------------------------
    pos_u_t px_reg      [0:ST_DLT];
    pos_s_t py_reg      [0:ST_DLT];
    noise_t nz_reg      [0:N];
    logic   zero_reg    [0:LAST];

    ang_t   vec_x_reg   [0:N];
    ang_t   vec_y_reg   [0:N];
    ang_t   vec_z_reg   [0:N];
    ang_t   vec_x_next  [0:N];
    ang_t   vec_y_next  [0:N];
    ang_t   vec_z_next  [0:N];

    ang_t   sum_reg;
    ang_t   sum_next;
    ang_t   wrap_reg;
    ang_t   wrap_next;

    ang_t   rot_x_reg   [ST_FOLD:ST_FOLD+N];
    ang_t   rot_y_reg   [ST_FOLD:ST_FOLD+N];
    ang_t   rot_t_reg   [ST_FOLD:ST_FOLD+N];
    ang_t   rot_x_next  [ST_FOLD:ST_FOLD+N];
    ang_t   rot_y_next  [ST_FOLD:ST_FOLD+N];
    ang_t   rot_t_next  [ST_FOLD:ST_FOLD+N];

    vel_t   hx_reg      [ST_RND:LAST];
    vel_t   hy_reg      [ST_RND:LAST];
    prod_t  prod_x_reg;
    prod_t  prod_y_reg;
    prod_t  prod_x_next;
    prod_t  prod_y_next;
    delta_t dx_reg;
    delta_t dy_reg;
    delta_t dx_next;
    delta_t dy_next;

    quo_t   quo_reg     [ST_POS:LAST];
    quo_t   quo_next    [ST_POS:LAST];
    frac_t  low_reg     [ST_POS:LAST];
    pos_s_t ny_reg      [ST_POS:LAST];
    pos_s_t ny_next;
    logic   sat_reg     [ST_POS:LAST];
    logic   sat_next;

    ang_t              vx_q30;
    ang_t              vy_q30;
    logic              vel_neg;
    logic              zero_in;
    logic signed [POS_W:0] ny_sum;
    logic [SUM_W:0]    x_sum;

    // round a Q30 component to Q.16 and clamp to +-1.0
    function automatic vel_t round_head(input ang_t v);
        ang_t r;
        r = (v + HEAD_ROUND) >>> Q30_SHIFT;
        if (r > ang_t'(HEAD_LIM))
            return HEAD_LIM;
        else if (r < -ang_t'(HEAD_LIM))
            return -HEAD_LIM;
        return r[VEL_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // stall chain: a stage moves when it is empty or its successor moves
    // ------------------------------------------------------------------
    always_comb
    begin
        en[LAST] = !v_reg[LAST] || result.ready;
        for (int s = LAST - 1; s >= 0; s--)
        begin
            en[s] = !v_reg[s] || en[s + 1];
        end
    end

    assign particle.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg          <= '0;
            box_length_reg <= BOX_LENGTH_RST;
            speed_reg      <= SPEED_RST;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= particle.valid;
            end
            for (int s = 1; s <= LAST; s++)
            begin
                if (en[s])
                begin
                    v_reg[s] <= v_reg[s - 1];
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BOX_LENGTH: box_length_reg <= cfg_data[BOX_W-1:0];
                    REG_SPEED:      speed_reg      <= cfg_data[SPEED_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    assign blen = (box_length_reg == '0) ? BLEN_W'(64'd1 << BOX_W) : BLEN_W'(box_length_reg);

    // ------------------------------------------------------------------
    // datapath next values
    // ------------------------------------------------------------------
    always_comb
    begin
        // input: velocity to Q30, left half-plane turned through pi
        vx_q30  = ang_t'(particle.vel_x) <<< Q30_SHIFT;
        vy_q30  = ang_t'(particle.vel_y) <<< Q30_SHIFT;
        vel_neg = vx_q30 < 0;
        zero_in = (particle.vel_x == '0) && (particle.vel_y == '0);
        vec_x_next[0] = vel_neg ? -vx_q30 : vx_q30;
        vec_y_next[0] = vel_neg ? -vy_q30 : vy_q30;
        vec_z_next[0] = vel_neg ? ANG_PI : '0;

        // vectoring: drive y to zero, collect the angle
        for (int k = 1; k <= N; k++)
        begin
            if (vec_y_reg[k - 1] >= 0)
            begin
                vec_x_next[k] = vec_x_reg[k - 1] + (vec_y_reg[k - 1] >>> (k - 1));
                vec_y_next[k] = vec_y_reg[k - 1] - (vec_x_reg[k - 1] >>> (k - 1));
                vec_z_next[k] = vec_z_reg[k - 1] + atan_q30(5'(k - 1));
            end
            else
            begin
                vec_x_next[k] = vec_x_reg[k - 1] - (vec_y_reg[k - 1] >>> (k - 1));
                vec_y_next[k] = vec_y_reg[k - 1] + (vec_x_reg[k - 1] >>> (k - 1));
                vec_z_next[k] = vec_z_reg[k - 1] - atan_q30(5'(k - 1));
            end
        end

        // zero velocity: heading angle taken as 0
        sum_next = (zero_reg[N] ? ang_t'(0) : vec_z_reg[N])
                 + (ang_t'(nz_reg[N]) <<< Q30_SHIFT) + ANG_PI;

        // sum lies in (-2pi, 4pi): one correction, three candidates
        if (sum_reg < 0)
            wrap_next = sum_reg + ANG_PI;
        else if (sum_reg >= ANG_TWO_PI)
            wrap_next = sum_reg - ANG_THREE_PI;
        else
            wrap_next = sum_reg - ANG_PI;

        // beyond +-pi/2: rotate through pi by negating the start vector
        rot_y_next[ST_FOLD] = '0;
        if (wrap_reg > ANG_HALF_PI)
        begin
            rot_t_next[ST_FOLD] = wrap_reg - ANG_PI;
            rot_x_next[ST_FOLD] = -INV_GAIN;
        end
        else if (wrap_reg < -ANG_HALF_PI)
        begin
            rot_t_next[ST_FOLD] = wrap_reg + ANG_PI;
            rot_x_next[ST_FOLD] = -INV_GAIN;
        end
        else
        begin
            rot_t_next[ST_FOLD] = wrap_reg;
            rot_x_next[ST_FOLD] = INV_GAIN;
        end

        // rotation: drive the residual angle to zero
        for (int s = ST_FOLD + 1; s <= ST_FOLD + N; s++)
        begin
            if (rot_t_reg[s - 1] >= 0)
            begin
                rot_x_next[s] = rot_x_reg[s - 1] - (rot_y_reg[s - 1] >>> (s - ST_FOLD - 1));
                rot_y_next[s] = rot_y_reg[s - 1] + (rot_x_reg[s - 1] >>> (s - ST_FOLD - 1));
                rot_t_next[s] = rot_t_reg[s - 1] - atan_q30(5'(s - ST_FOLD - 1));
            end
            else
            begin
                rot_x_next[s] = rot_x_reg[s - 1] + (rot_y_reg[s - 1] >>> (s - ST_FOLD - 1));
                rot_y_next[s] = rot_y_reg[s - 1] - (rot_x_reg[s - 1] >>> (s - ST_FOLD - 1));
                rot_t_next[s] = rot_t_reg[s - 1] + atan_q30(5'(s - ST_FOLD - 1));
            end
        end

        // step
        prod_x_next = prod_t'($signed({1'b0, speed_reg})) * prod_t'(hx_reg[ST_RND]);
        prod_y_next = prod_t'($signed({1'b0, speed_reg})) * prod_t'(hy_reg[ST_RND]);
        dx_next = DELTA_W'((prod_x_reg + PROD_ROUND) >>> FRAC_BITS);
        dy_next = DELTA_W'((prod_y_reg + PROD_ROUND) >>> FRAC_BITS);

        // y: saturate on overflow of the field
        ny_sum   = (POS_W + 1)'(py_reg[ST_DLT]) + (POS_W + 1)'(dy_reg);
        sat_next = ny_sum[POS_W] != ny_sum[POS_W-1];
        if (sat_next)
            ny_next = ny_sum[POS_W] ? POS_MIN : POS_MAX;
        else
            ny_next = ny_sum[POS_W-1:0];

        // x: add four box lengths so the sum is never negative
        x_sum = (SUM_W + 1)'(px_reg[ST_DLT]) + (SUM_W + 1)'(dx_reg)
              + ((SUM_W + 1)'(blen) << (FRAC_BITS + 2));
        quo_next[ST_POS] = x_sum[SUM_W-1:FRAC_BITS];

        // restoring remainder of the whole-unit part by box length
        for (int s = ST_POS + 1; s <= LAST; s++)
        begin
            if (POS_W'(quo_reg[s - 1]) >= (POS_W'(blen) << (LAST - s)))
                quo_next[s] = quo_reg[s - 1] - QUO_W'(POS_W'(blen) << (LAST - s));
            else
                quo_next[s] = quo_reg[s - 1];
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            px_reg[0]    <= particle.pos_x;
            py_reg[0]    <= particle.pos_y;
            nz_reg[0]    <= particle.noise_angle;
            zero_reg[0]  <= zero_in;
            vec_x_reg[0] <= vec_x_next[0];
            vec_y_reg[0] <= vec_y_next[0];
            vec_z_reg[0] <= vec_z_next[0];
        end
        for (int s = 1; s <= N; s++)
        begin
            if (en[s])
            begin
                vec_x_reg[s] <= vec_x_next[s];
                vec_y_reg[s] <= vec_y_next[s];
                vec_z_reg[s] <= vec_z_next[s];
                nz_reg[s]    <= nz_reg[s - 1];
            end
        end
        for (int s = 1; s <= ST_DLT; s++)
        begin
            if (en[s])
            begin
                px_reg[s] <= px_reg[s - 1];
                py_reg[s] <= py_reg[s - 1];
            end
        end
        for (int s = 1; s <= LAST; s++)
        begin
            if (en[s])
            begin
                zero_reg[s] <= zero_reg[s - 1];
            end
        end
        if (en[ST_SUM])
        begin
            sum_reg <= sum_next;
        end
        if (en[ST_WRAP])
        begin
            wrap_reg <= wrap_next;
        end
        for (int s = ST_FOLD; s <= ST_FOLD + N; s++)
        begin
            if (en[s])
            begin
                rot_x_reg[s] <= rot_x_next[s];
                rot_y_reg[s] <= rot_y_next[s];
                rot_t_reg[s] <= rot_t_next[s];
            end
        end
        if (en[ST_RND])
        begin
            hx_reg[ST_RND] <= round_head(rot_x_reg[ST_FOLD + N]);
            hy_reg[ST_RND] <= round_head(rot_y_reg[ST_FOLD + N]);
        end
        for (int s = ST_RND + 1; s <= LAST; s++)
        begin
            if (en[s])
            begin
                hx_reg[s] <= hx_reg[s - 1];
                hy_reg[s] <= hy_reg[s - 1];
            end
        end
        if (en[ST_MUL])
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
        end
        if (en[ST_DLT])
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (en[ST_POS])
        begin
            quo_reg[ST_POS] <= quo_next[ST_POS];
            low_reg[ST_POS] <= x_sum[FRAC_BITS-1:0];
            ny_reg[ST_POS]  <= ny_next;
            sat_reg[ST_POS] <= sat_next;
        end
        for (int s = ST_POS + 1; s <= LAST; s++)
        begin
            if (en[s])
            begin
                quo_reg[s] <= quo_next[s];
                low_reg[s] <= low_reg[s - 1];
                ny_reg[s]  <= ny_reg[s - 1];
                sat_reg[s] <= sat_reg[s - 1];
            end
        end
    end

    // ------------------------------------------------------------------
    // result channel: last stage is the output register
    // ------------------------------------------------------------------
    assign result.valid         = v_reg[LAST];
    assign result.new_x         = {quo_reg[LAST][BOX_W-1:0], low_reg[LAST]};
    assign result.new_y         = ny_reg[LAST];
    assign result.new_vx        = hx_reg[LAST];
    assign result.new_vy        = hy_reg[LAST];
    assign result.y_saturated   = sat_reg[LAST];
    assign result.zero_velocity = zero_reg[LAST];

endmodule

// ===== sv/phns_checker.sv =====
// ----------------------------------------------------------------------------
// phns_checker: port-level assertions for the particle heading/noise step unit
// Watches the config port and both channels; bound to the top level.
// ----------------------------------------------------------------------------
module phns_checker
    import phns_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      cfg_we,
    input cfg_idx_t  cfg_index,
    input cfg_data_t cfg_data,
    input logic      particle_valid,
    input logic      particle_ready,
    input logic      result_valid,
    input logic      result_ready,
    input pos_u_t    new_x,
    input pos_s_t    new_y,
    input vel_t      new_vx,
    input vel_t      new_vy,
    input logic      y_saturated,
    input logic      zero_velocity
);

    box_t        box_reg;
    logic [15:0] inflight_reg;
    logic        dirty_reg;
    logic        take_in;
    logic        take_out;

    assign take_in  = particle_valid && particle_ready;
    assign take_out = result_valid && result_ready;

    // mirror of box_length; a write with items in flight leaves it unusable
    // until the pipe drains
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg      <= BOX_LENGTH_RST;
            inflight_reg <= '0;
            dirty_reg    <= 1'b0;
        end
        else
        begin
            inflight_reg <= inflight_reg + 16'(take_in) - 16'(take_out);
            if (cfg_we && cfg_index == REG_BOX_LENGTH)
            begin
                box_reg <= cfg_data[BOX_W-1:0];
            end
            if (cfg_we && cfg_index == REG_BOX_LENGTH && inflight_reg != '0)
                dirty_reg <= 1'b1;
            else if (inflight_reg == '0)
                dirty_reg <= 1'b0;
        end
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result valid dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(new_x) && $stable(new_y)
            && $stable(new_vx) && $stable(new_vy) && $stable(y_saturated)
            && $stable(zero_velocity))
        else $error("result payload changed while stalled");

    a_x_in_box: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !dirty_reg && box_reg != '0 |-> new_x[POS_W-1:FRAC_BITS] < box_reg)
        else $error("new_x outside the box");

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && y_saturated |-> new_y == POS_MAX || new_y == POS_MIN)
        else $error("y flagged saturated but not at a limit");

endmodule

bind particle_heading_noise_step_unit phns_checker u_phns_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .particle_valid (particle.valid),
    .particle_ready (particle.ready),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .new_x          (result.new_x),
    .new_y          (result.new_y),
    .new_vx         (result.new_vx),
    .new_vy         (result.new_vy),
    .y_saturated    (result.y_saturated),
    .zero_velocity  (result.zero_velocity)
);

// ===== tb/particle_heading_noise_step_unit_test.sv =====
// ----------------------------------------------------------------------------
// particle_heading_noise_step_unit_test: regression for the particle step unit
// Drives particles through the valid/ready input, predicts each move with an
// independent fixed-point CORDIC model and checks every result field by field.
// Covers heading edge cases, box and speed limits, random settings, output
// back-pressure and a gap-free stream.
// ----------------------------------------------------------------------------
module particle_heading_noise_step_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import phns_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 11;
    localparam int PIPE_LATENCY    = 2 * CORDIC_STEPS_DEF + 22;
    localparam int STALL_LIMIT     = 4000;   // cycles with no transfer on either side
    localparam int HOLD_OFF_CYCLES = 300;    // long receiver stall, far past pipe depth
    localparam int IDLE_PERCENT    = 28;
    localparam int REPORT_CAP      = 200;    // keep a badly broken run readable

    // register values after reset
    localparam box_t   BOX_AT_RESET   = 12'd256;
    localparam speed_t SPEED_AT_RESET = 17'd32768;

    typedef struct {
        pos_u_t pos_x;
        pos_s_t pos_y;
        vel_t   vel_x;
        vel_t   vel_y;
        noise_t noise_angle;
    } particle_t;

    typedef struct {
        pos_u_t new_x;
        pos_s_t new_y;
        vel_t   new_vx;
        vel_t   new_vy;
        logic   y_saturated;
        logic   zero_velocity;
    } move_t;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    cfg_idx_t  cfg_index;
    cfg_data_t cfg_data;

    phns_particle_if particle_bus ();
    phns_result_if   result_bus ();

    particle_heading_noise_step_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .particle  (particle_bus),
        .result    (result_bus)
    );

    // predictor's copy of the registers
    box_t   model_box;
    speed_t model_speed;

    move_t  pending_moves[$];   // predicted moves, oldest first
    int     mismatch_count;
    int     moves_checked;
    bit     no_idling;          // both sides run flat out while set
    int     hold_off_left;      // receiver stall still to go, in cycles

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    // atan(2^-i), Q30, truncated
    function automatic longint cordic_atan(int i);
        case (i)
            0:       return 843314856;
            1:       return 497837829;
            2:       return 263043836;
            3:       return 133525158;
            4:       return 67021686;
            5:       return 33543515;
            6:       return 16775850;
            7:       return 8388437;
            8:       return 4194282;
            9:       return 2097149;
            10:      return 1048575;
            11:      return 524287;
            12:      return 262143;
            13:      return 131071;
            14:      return 65535;
            15:      return 32767;
            16:      return 16383;
            17:      return 8191;
            18:      return 4095;
            19:      return 2047;
            20:      return 1023;
            21:      return 511;
            22:      return 255;
            23:      return 127;
            default: return 0;
        endcase
    endfunction

    // Move of one particle under the current register copy. All shifts of
    // signed values are arithmetic (floor), as in the block.
    function automatic move_t predict_move(particle_t p);
        longint px, py, vx, vy, nz, up, lim;
        longint x, y, z, t, r, xs, ys;
        longint hx, hy, dx, dy, blen, len, nx, ny;
        int     steps;
        bit     zero, sat;
        move_t  m;

        up    = longint'(1) << Q30_SHIFT;
        px    = longint'(p.pos_x);
        py    = longint'(p.pos_y);
        vx    = longint'(p.vel_x);
        vy    = longint'(p.vel_y);
        nz    = longint'(p.noise_angle);
        zero  = (vx == 0) && (vy == 0);
        sat   = 1'b0;
        steps = (CORDIC_STEPS_DEF > 24) ? 24 : CORDIC_STEPS_DEF;

        // vectoring: heading angle of the velocity, 0 for a still particle
        z = 0;
        if (!zero)
        begin
            x = vx * up;
            y = vy * up;
            if (x < 0)
            begin
                x = -x;
                y = -y;
                z = longint'(ANG_PI);
            end
            for (int i = 0; i < steps; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + cordic_atan(i);
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - cordic_atan(i);
                end
            end
        end

        // add noise and fold into [-pi, pi)
        t = z + nz * up + longint'(ANG_PI);
        r = t % longint'(ANG_TWO_PI);
        if (r < 0)
            r = r + longint'(ANG_TWO_PI);
        t = r - longint'(ANG_PI);

        // rotation, half-turn pre-rotation for angles past +-pi/2
        x = longint'(INV_GAIN);
        y = 0;
        if (t > longint'(ANG_HALF_PI))
        begin
            t = t - longint'(ANG_PI);
            x = -longint'(INV_GAIN);
        end
        else if (t < -longint'(ANG_HALF_PI))
        begin
            t = t + longint'(ANG_PI);
            x = -longint'(INV_GAIN);
        end
        for (int i = 0; i < steps; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (t >= 0)
            begin
                x = x - ys;
                y = y + xs;
                t = t - cordic_atan(i);
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                t = t + cordic_atan(i);
            end
        end

        // heading: round half up from Q30, clamp to +-1.0
        lim = longint'(1) << FRAC_BITS;
        if (lim > 131071)
            lim = 131071;
        hx = (x + (up >>> 1)) >>> Q30_SHIFT;
        hy = (y + (up >>> 1)) >>> Q30_SHIFT;
        if (hx > lim)
            hx = lim;
        else if (hx < -lim)
            hx = -lim;
        if (hy > lim)
            hy = lim;
        else if (hy < -lim)
            hy = -lim;

        // step from the rounded heading
        dx = (longint'(model_speed) * hx + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
        dy = (longint'(model_speed) * hy + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;

        // x: full modulo of the box, box 0 means 4096
        if (model_box == '0)
            blen = 4096;
        else
            blen = longint'(model_box);
        len = blen << FRAC_BITS;
        nx  = (px + dx) % len;
        if (nx < 0)
            nx = nx + len;

        // y: clip at the field limits
        ny = py + dy;
        if (ny > longint'(POS_MAX))
        begin
            ny  = longint'(POS_MAX);
            sat = 1'b1;
        end
        else if (ny < longint'(POS_MIN))
        begin
            ny  = longint'(POS_MIN);
            sat = 1'b1;
        end

        m.new_x         = pos_u_t'(nx);
        m.new_y         = pos_s_t'(ny);
        m.new_vx        = vel_t'(hx);
        m.new_vy        = vel_t'(hy);
        m.y_saturated   = sat;
        m.zero_velocity = zero;
        return m;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic particle_t make_particle(longint px, longint py, longint vx,
                                                longint vy, longint nz);
        particle_t p;

        p.pos_x       = pos_u_t'(px);
        p.pos_y       = pos_s_t'(py);
        p.vel_x       = vel_t'(vx);
        p.vel_y       = vel_t'(vy);
        p.noise_angle = noise_t'(nz);
        return p;
    endfunction

    // velocity component within +-1.0
    function automatic vel_t random_unit_vel();
        return vel_t'(int'($urandom_range(131072)) - 65536);
    endfunction

    // Mostly well-formed particles: x inside the box, noise within +-pi.
    // The rest exercises the full field ranges and the limits of y.
    function automatic particle_t random_particle();
        particle_t p;
        longint    len;
        int        pick;

        if (model_box == '0)
            len = longint'(4096) << FRAC_BITS;
        else
            len = longint'(model_box) << FRAC_BITS;

        if ($urandom_range(9) == 0)
            p.pos_x = pos_u_t'($urandom);
        else
            p.pos_x = pos_u_t'($urandom_range(32'(len - 1)));

        pick = $urandom_range(9);
        if (pick == 0)
            p.pos_y = POS_MAX - pos_s_t'($urandom_range(140000));
        else if (pick == 1)
            p.pos_y = POS_MIN + pos_s_t'($urandom_range(140000));
        else
            p.pos_y = pos_s_t'($urandom);

        pick = $urandom_range(19);
        if (pick <= 1)
        begin
            p.vel_x = '0;
            p.vel_y = '0;
        end
        else if (pick == 2)
        begin
            p.vel_x = '0;
            p.vel_y = random_unit_vel();
        end
        else if (pick == 3)
        begin
            p.vel_x = random_unit_vel();
            p.vel_y = '0;
        end
        else if (pick <= 5)
        begin
            p.vel_x = vel_t'($urandom);
            p.vel_y = vel_t'($urandom);
        end
        else
        begin
            p.vel_x = random_unit_vel();
            p.vel_y = random_unit_vel();
        end

        pick = $urandom_range(19);
        if (pick == 0)
            p.noise_angle = '0;
        else if (pick <= 3)
            p.noise_angle = noise_t'($urandom);
        else
            p.noise_angle = noise_t'(int'($urandom_range(411774)) - 205887);
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // drivers; every task returns right after a rising edge
    // ------------------------------------------------------------------------
    // Register write, one cycle of write enable. Only called with the pipe empty.
    task automatic write_register(cfg_idx_t idx, cfg_data_t data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_BOX_LENGTH)
            model_box = data[BOX_W-1:0];
        else if (idx == REG_SPEED)
            model_speed = data[SPEED_W-1:0];
    endtask

    // One particle transfer. valid stays high on return so back-to-back items
    // need no second assignment in the same step. The handshake is sampled at
    // the falling edge, where valid and ready are settled for the next rise.
    task automatic send_particle(particle_t p);
        bit taken;

        while (!no_idling && $urandom_range(99) < IDLE_PERCENT)
        begin
            particle_bus.valid <= 1'b0;
            @(posedge clk);
        end
        particle_bus.valid       <= 1'b1;
        particle_bus.pos_x       <= p.pos_x;
        particle_bus.pos_y       <= p.pos_y;
        particle_bus.vel_x       <= p.vel_x;
        particle_bus.vel_y       <= p.vel_y;
        particle_bus.noise_angle <= p.noise_angle;
        do
        begin
            @(negedge clk);
            taken = (particle_bus.ready === 1'b1);
            if (taken)
                pending_moves.push_back(predict_move(p));
            @(posedge clk);
        end
        while (!taken);
    endtask

    // Sender pauses until every predicted move has come out.
    task automatic wait_for_moves();
        particle_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_moves.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // receiver: random ready, or a long counted hold-off when requested
    // ------------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off_left > 0)
            begin
                result_bus.ready <= 1'b0;
                hold_off_left--;
            end
            else if (no_idling)
                result_bus.ready <= 1'b1;
            else
                result_bus.ready <= ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
            $display("[%0t] MISMATCH move %0d: %s", $realtime, moves_checked, what);
    endtask

    task automatic check_move();
        move_t want;

        if (pending_moves.size() == 0)
        begin
            report_mismatch($sformatf("result with nothing pending (new_x %0d new_y %0d)",
                                      result_bus.new_x, result_bus.new_y));
            return;
        end
        want = pending_moves.pop_front();
        if (result_bus.new_x !== want.new_x)
            report_mismatch($sformatf("new_x got %0d expected %0d",
                                      result_bus.new_x, want.new_x));
        if (result_bus.new_y !== want.new_y)
            report_mismatch($sformatf("new_y got %0d expected %0d",
                                      result_bus.new_y, want.new_y));
        if (result_bus.new_vx !== want.new_vx)
            report_mismatch($sformatf("new_vx got %0d expected %0d",
                                      result_bus.new_vx, want.new_vx));
        if (result_bus.new_vy !== want.new_vy)
            report_mismatch($sformatf("new_vy got %0d expected %0d",
                                      result_bus.new_vy, want.new_vy));
        if (result_bus.y_saturated !== want.y_saturated)
            report_mismatch($sformatf("y_saturated got %b expected %b",
                                      result_bus.y_saturated, want.y_saturated));
        if (result_bus.zero_velocity !== want.zero_velocity)
            report_mismatch($sformatf("zero_velocity got %b expected %b",
                                      result_bus.zero_velocity, want.zero_velocity));
        moves_checked++;
    endtask

    // result transfers, sampled at the falling edge
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rst_n === 1'b1 && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
                check_move();
        end
    end

    // watchdog: too long without a transfer on either channel ends the run
    initial
    begin : watchdog
        int quiet_cycles;

        quiet_cycles = 0;
        wait (rst_n === 1'b1);
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(negedge clk);
            if ((particle_bus.valid === 1'b1 && particle_bus.ready === 1'b1) ||
                (result_bus.valid === 1'b1 && result_bus.ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[%0t] watchdog: %0d cycles without a transfer", $realtime, STALL_LIMIT);
        $display("particle_heading_noise_step_unit regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // Heading corner cases at reset settings (box 256, speed 0.5): still
    // particle, axis and diagonal directions, angles that wrap past +-pi,
    // noise and velocity at the ends of their fields.
    task automatic test_heading_cases();
        send_particle(make_particle(0, 0, 0, 0, 0));
        send_particle(make_particle(100 << 16, 5 << 16, 0, 0, 205887));
        send_particle(make_particle(200 << 16, -(5 << 16), 0, 0, -205887));
        send_particle(make_particle(10 << 16, 0, 65536, 0, 0));
        send_particle(make_particle(10 << 16, 0, -65536, 0, 0));      // heading pi
        send_particle(make_particle(10 << 16, 0, 0, 65536, 0));
        send_particle(make_particle(10 << 16, 0, 0, -65536, 0));
        send_particle(make_particle(50 << 16, 0, -65536, 1, 205887));  // sum past +pi
        send_particle(make_particle(50 << 16, 0, -65536, -1, -205887)); // sum past -pi
        send_particle(make_particle(1, 1, 65536, 65536, 262143));
        send_particle(make_particle(1, -1, -65536, 65536, -262144));
        send_particle(make_particle(255 << 16, 0, 131071, -131072, 0));
        send_particle(make_particle(128 << 16, 0, -131072, 131071, 1));
        wait_for_moves();
    endtask

    // Box and speed at their extremes: x wrap both ways, x given beyond the
    // box, y clipping at both limits, zero speed, box 0 read as 4096.
    task automatic test_box_and_speed_limits();
        write_register(REG_BOX_LENGTH, 17'd0);
        write_register(REG_SPEED, 17'd131071);
        send_particle(make_particle(268435455, 0, 65536, 0, 0));
        send_particle(make_particle(0, 0, -65536, 0, 0));
        send_particle(make_particle(1000, longint'(POS_MAX), 0, 65536, 0));
        send_particle(make_particle(1000, longint'(POS_MIN), 0, -65536, 0));
        wait_for_moves();

        // upper data bits set: only the low 12 reach box_length
        write_register(REG_BOX_LENGTH, 17'h1F001);
        write_register(REG_SPEED, 17'd0);
        send_particle(make_particle(268435455, longint'(POS_MAX), 0, 65536, 0));
        send_particle(make_particle(65535, longint'(POS_MIN), 0, -65536, 100));
        wait_for_moves();

        write_register(REG_BOX_LENGTH, 17'd4095);
        write_register(REG_SPEED, 17'd65536);
        send_particle(make_particle((4095 << 16) - 1, 0, 65536, 0, 0));
        send_particle(make_particle(0, longint'(POS_MAX) - 100, 0, 65536, 0));
        send_particle(make_particle(12345, longint'(POS_MIN) + 100, 3, -7, -205887));
        wait_for_moves();
    endtask

    // Random particles under a run of settings, extremes first. An
    // occasional pause mid-phase lets the pipe empty completely.
    task automatic test_random_settings();
        cfg_data_t box_set[6];
        cfg_data_t speed_set[6];

        box_set[0]   = 17'd4095;
        speed_set[0] = 17'd65536;
        box_set[1]   = 17'd1;
        speed_set[1] = 17'd131071;
        box_set[2]   = 17'd0;
        speed_set[2] = 17'd1;
        for (int k = 3; k < 6; k++)
        begin
            box_set[k]   = cfg_data_t'($urandom);
            speed_set[k] = cfg_data_t'($urandom);
        end
        for (int k = 0; k < 6; k++)
        begin
            write_register(REG_BOX_LENGTH, box_set[k]);
            write_register(REG_SPEED, speed_set[k]);
            for (int n = 0; n < 70; n++)
            begin
                send_particle(random_particle());
                if ($urandom_range(59) == 0)
                    wait_for_moves();
            end
            wait_for_moves();
        end
    endtask

    // Receiver stalls far longer than the pipe is deep while the sender keeps
    // offering; the block must fill, drop ready and lose nothing.
    task automatic test_output_backpressure();
        write_register(REG_SPEED, cfg_data_t'($urandom));
        @(negedge clk);
        hold_off_left = HOLD_OFF_CYCLES;
        @(posedge clk);
        no_idling = 1'b1;
        for (int n = 0; n < 120; n++)
            send_particle(random_particle());
        no_idling = 1'b0;
        wait_for_moves();
    endtask

    // Long stretch with no idling on either side, one transfer per cycle.
    task automatic test_steady_stream();
        write_register(REG_BOX_LENGTH, cfg_data_t'($urandom));
        no_idling = 1'b1;
        for (int n = 0; n < 100; n++)
            send_particle(random_particle());
        no_idling = 1'b0;
        wait_for_moves();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n                    = 1'b0;
        cfg_we                   = 1'b0;
        cfg_index                = REG_BOX_LENGTH;
        cfg_data                 = '0;
        particle_bus.valid       = 1'b0;
        particle_bus.pos_x       = '0;
        particle_bus.pos_y       = '0;
        particle_bus.vel_x       = '0;
        particle_bus.vel_y       = '0;
        particle_bus.noise_angle = '0;
        result_bus.ready         = 1'b0;
        model_box                = BOX_AT_RESET;
        model_speed              = SPEED_AT_RESET;
        mismatch_count           = 0;
        moves_checked            = 0;
        no_idling                = 1'b0;
        hold_off_left            = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_heading_cases();
        test_box_and_speed_limits();
        test_random_settings();
        test_output_backpressure();
        test_steady_stream();

        // all predicted moves are in; give a stray result time to show up
        wait_for_moves();
        repeat (PIPE_LATENCY + 10) @(posedge clk);

        if (mismatch_count == 0)
            $display("particle_heading_noise_step_unit regression: pass");
        else
            $display("particle_heading_noise_step_unit regression: fail");
        $finish;
    end

endmodule
